[rtl/first_fit_allocator_timed_release_defines.svh]
// ------------------------------------------------------------------------
// Assertion macros for the first-fit allocator
// Shared property templates used by the port-level checker.
// ------------------------------------------------------------------------
`ifndef FIRST_FIT_ALLOCATOR_TIMED_RELEASE_DEFINES_SVH
`define FIRST_FIT_ALLOCATOR_TIMED_RELEASE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ffa_pkg.sv]
// ------------------------------------------------------------------------
// ffa_pkg
// Types, sizes and command codes shared by the allocator modules.
// ------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int QUEUE_DEPTH = 64;

  localparam int BLK_AW = $clog2(MAX_BLOCKS);
  localparam int BLK_CW = $clog2(MAX_BLOCKS + 1);
  localparam int Q_AW   = $clog2(QUEUE_DEPTH);
  localparam int Q_CW   = $clog2(QUEUE_DEPTH + 1);

  localparam int MEM_SIZE_RESET = 1024;

  // One allocated block, table kept sorted by start
  typedef struct packed {
    logic [23:0] start;
    logic [23:0] len;
    logic [31:0] rel;
  } blk_entry_t;

  // One waiting request
  typedef struct packed {
    logic [23:0] len;
    logic [30:0] hold;
  } q_entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MIN_INIT,
    OP_MIN_STEP,
    OP_CMP_INIT,
    OP_CMP_STEP,
    OP_CMP_END,
    OP_ITEM_PARAMS,
    OP_Q_PARAMS,
    OP_FIT_INIT,
    OP_FIT_STEP,
    OP_FIT_END,
    OP_SHIFT_INIT,
    OP_SHIFT_WR,
    OP_INSERT,
    OP_OVF,
    OP_Q_PUSH,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_prev;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic idx_last;
    logic min_gt_limit;
    logic is_finish;
    logic fit_hit;
    logic found;
    logic tbl_full;
    logic q_empty;
    logic q_full;
    logic idx_eq_slot;
    logic retry;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MIN_START,
    S_MIN_RQ,
    S_MIN_CHK,
    S_MIN_END,
    S_CMP_RQ,
    S_CMP_CHK,
    S_CMP_END,
    S_RETRY,
    S_RETRY_LD,
    S_REL_DONE,
    S_FIT_START,
    S_FIT_RQ,
    S_FIT_CHK,
    S_FIT_END,
    S_FIT_DECIDE,
    S_SHIFT,
    S_SHIFT_RQ,
    S_SHIFT_WR,
    S_INSERT,
    S_OUT
  } ctrl_state_t;

endpackage

`default_nettype wire

[rtl/ffa_ctrl.sv]
// ------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: release groups, queue retries, first-fit scan and insert.
// ------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  ffa_pkg::dp_sts_t sts,
  output ffa_pkg::dp_cmd_t cmd
);
  import ffa_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:       if (in_valid) state_nxt = S_MIN_START;
      S_MIN_START:  state_nxt = sts.cnt_zero ? S_REL_DONE : S_MIN_RQ;
      S_MIN_RQ:     state_nxt = S_MIN_CHK;
      S_MIN_CHK:    state_nxt = sts.idx_last ? S_MIN_END : S_MIN_RQ;
      S_MIN_END:    state_nxt = sts.min_gt_limit ? S_REL_DONE : S_CMP_RQ;
      S_CMP_RQ:     state_nxt = S_CMP_CHK;
      S_CMP_CHK:    state_nxt = sts.idx_last ? S_CMP_END : S_CMP_RQ;
      S_CMP_END:    state_nxt = S_RETRY;
      S_RETRY:      state_nxt = sts.q_empty ? S_MIN_START : S_RETRY_LD;
      S_RETRY_LD:   state_nxt = S_FIT_START;
      S_REL_DONE:   state_nxt = sts.is_finish ? S_OUT : S_FIT_START;
      S_FIT_START:  state_nxt = sts.cnt_zero ? S_FIT_END : S_FIT_RQ;
      S_FIT_RQ:     state_nxt = S_FIT_CHK;
      S_FIT_CHK: begin
        if (sts.fit_hit) state_nxt = S_FIT_DECIDE;
        else if (sts.idx_last) state_nxt = S_FIT_END;
        else state_nxt = S_FIT_RQ;
      end
      S_FIT_END:    state_nxt = S_FIT_DECIDE;
      S_FIT_DECIDE: begin
        if (sts.found && !sts.tbl_full) state_nxt = S_SHIFT;
        else if (sts.retry) state_nxt = S_MIN_START;
        else state_nxt = S_OUT;
      end
      S_SHIFT:      state_nxt = sts.idx_eq_slot ? S_INSERT : S_SHIFT_RQ;
      S_SHIFT_RQ:   state_nxt = S_SHIFT_WR;
      S_SHIFT_WR:   state_nxt = S_SHIFT;
      S_INSERT:     state_nxt = sts.retry ? S_RETRY : S_OUT;
      S_OUT:        if (sts.out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd.op      = OP_NONE;
    cmd.rd_prev = 1'b0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_MIN_START:  if (!sts.cnt_zero) cmd.op = OP_MIN_INIT;
      S_MIN_CHK:    cmd.op = OP_MIN_STEP;
      S_MIN_END:    if (!sts.min_gt_limit) cmd.op = OP_CMP_INIT;
      S_CMP_CHK:    cmd.op = OP_CMP_STEP;
      S_CMP_END:    cmd.op = OP_CMP_END;
      S_RETRY_LD:   cmd.op = OP_Q_PARAMS;
      S_REL_DONE:   if (!sts.is_finish) cmd.op = OP_ITEM_PARAMS;
      S_FIT_START:  cmd.op = OP_FIT_INIT;
      S_FIT_CHK:    cmd.op = OP_FIT_STEP;
      S_FIT_END:    cmd.op = OP_FIT_END;
      S_FIT_DECIDE: begin
        if (sts.found && !sts.tbl_full) cmd.op = OP_SHIFT_INIT;
        else if (!sts.retry) cmd.op = (sts.found || sts.q_full) ? OP_OVF : OP_Q_PUSH;
      end
      S_SHIFT_RQ:   cmd.rd_prev = 1'b1;
      S_SHIFT_WR:   cmd.op = OP_SHIFT_WR;
      S_INSERT:     cmd.op = OP_INSERT;
      S_OUT:        if (sts.out_free) cmd.op = OP_OUT;
      default:      cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ffa_dp.sv]
// ------------------------------------------------------------------------
// ffa_dp
// Block table, wait queue, counters and the result register.
// ------------------------------------------------------------------------
`default_nettype none

module ffa_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [23:0]        cfg_wdata,
  input  wire                in_req_type,
  input  wire  [30:0]        in_arrival_time,
  input  wire  [23:0]        in_block_length,
  input  wire  [30:0]        in_hold_time,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_placed_now,
  output logic [23:0]        out_start_address,
  output logic [31:0]        out_waited_total,
  output logic [31:0]        out_last_release_time,
  output logic               out_overflow,
  input  ffa_pkg::dp_cmd_t   cmd,
  output ffa_pkg::dp_sts_t   sts
);
  import ffa_pkg::*;

  blk_entry_t tbl_mem [MAX_BLOCKS];
  q_entry_t   q_mem   [QUEUE_DEPTH];

  logic [23:0]       mem_size_r;
  logic [BLK_CW-1:0] blk_cnt_r;
  logic [Q_AW-1:0]   q_head_r, q_tail_r;
  logic [Q_CW-1:0]   q_cnt_r;
  logic [31:0]       wait_r, last_rel_r;
  logic              out_valid_r;

  logic              type_r;
  logic [30:0]       arr_r;
  logic [23:0]       len_r;
  logic [30:0]       hold_r;
  logic [BLK_CW-1:0] idx_r, wr_r, slot_r;
  logic [31:0]       min_r, now_r;
  logic [24:0]       pos_r;
  logic              found_r, retry_r;
  logic [23:0]       plen_r;
  logic [30:0]       phold_r;
  logic              res_placed_r, res_ovf_r;
  logic [23:0]       res_addr_r;
  blk_entry_t        rd_r;
  q_entry_t          q_rd_r;

  logic              out_placed_r, out_ovf_r;
  logic [23:0]       out_addr_r;
  logic [31:0]       out_wait_r, out_rel_r;

  logic [BLK_CW-1:0] idx_m1, idx_p1;
  logic [BLK_AW-1:0] rd_addr, wr_addr;
  logic              wr_en;
  blk_entry_t        wr_data;
  logic [31:0]       limit;
  logic [24:0]       gap, end_gap, mem_ext, blk_end;
  logic              fit_hit, end_ok;
  logic [32:0]       rel_sum;
  logic [31:0]       rel_sat;
  logic [Q_AW-1:0]   q_head_inc, q_tail_inc;

  assign idx_m1  = idx_r - BLK_CW'(1);
  assign idx_p1  = idx_r + BLK_CW'(1);
  assign rd_addr = cmd.rd_prev ? idx_m1[BLK_AW-1:0] : idx_r[BLK_AW-1:0];
  assign limit   = type_r ? 32'hFFFF_FFFF : {1'b0, arr_r};

  // Gap before the block under scan and gap at the top of memory
  assign gap     = {1'b0, rd_r.start} - pos_r;
  assign fit_hit = ({1'b0, rd_r.start} >= pos_r) && (gap >= {1'b0, plen_r});
  assign mem_ext = {1'b0, mem_size_r};
  assign end_gap = mem_ext - pos_r;
  assign end_ok  = (mem_ext >= pos_r) && (end_gap >= {1'b0, plen_r});
  assign blk_end = {1'b0, rd_r.start} + {1'b0, rd_r.len};

  // Saturating release time
  assign rel_sum = {1'b0, now_r} + {2'b00, phold_r};
  assign rel_sat = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];

  assign q_head_inc = (q_head_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + Q_AW'(1);
  assign q_tail_inc = (q_tail_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + Q_AW'(1);

  // Select table write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[BLK_AW-1:0];
    wr_data = rd_r;
    case (cmd.op)
      OP_CMP_STEP: begin
        wr_en   = (rd_r.rel != min_r);
        wr_addr = wr_r[BLK_AW-1:0];
      end
      OP_SHIFT_WR: wr_en = 1'b1;
      OP_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = slot_r[BLK_AW-1:0];
        wr_data = '{start: pos_r[23:0], len: plen_r, rel: rel_sat};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Table and queue memories
  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    rd_r <= tbl_mem[rd_addr];
    if (cmd.op == OP_Q_PUSH) q_mem[q_tail_r] <= '{len: len_r, hold: hold_r};
    q_rd_r <= q_mem[q_head_r];
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r  <= 24'(MEM_SIZE_RESET);
      blk_cnt_r   <= '0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      q_cnt_r     <= '0;
      wait_r      <= '0;
      last_rel_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mem_size_r <= cfg_wdata;
      // Raise on a new result word, drop once it is taken
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CMP_INIT: last_rel_r <= min_r;
        OP_CMP_END:  blk_cnt_r <= wr_r;
        OP_INSERT: begin
          blk_cnt_r <= blk_cnt_r + BLK_CW'(1);
          if (retry_r) begin
            q_head_r <= q_head_inc;
            q_cnt_r  <= q_cnt_r - Q_CW'(1);
          end
        end
        OP_Q_PUSH: begin
          q_tail_r <= q_tail_inc;
          q_cnt_r  <= q_cnt_r + Q_CW'(1);
          wait_r   <= wait_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        type_r       <= in_req_type;
        arr_r        <= in_arrival_time;
        len_r        <= in_block_length;
        hold_r       <= in_hold_time;
        res_placed_r <= 1'b0;
        res_addr_r   <= '0;
        res_ovf_r    <= 1'b0;
      end
      OP_MIN_INIT: begin
        idx_r <= '0;
        min_r <= 32'hFFFF_FFFF;
      end
      OP_MIN_STEP: begin
        if (rd_r.rel < min_r) min_r <= rd_r.rel;
        idx_r <= idx_p1;
      end
      OP_CMP_INIT: begin
        idx_r <= '0;
        wr_r  <= '0;
      end
      OP_CMP_STEP: begin
        if (rd_r.rel != min_r) wr_r <= wr_r + BLK_CW'(1);
        idx_r <= idx_p1;
      end
      OP_ITEM_PARAMS: begin
        retry_r <= 1'b0;
        now_r   <= {1'b0, arr_r};
        plen_r  <= len_r;
        phold_r <= hold_r;
      end
      OP_Q_PARAMS: begin
        retry_r <= 1'b1;
        now_r   <= min_r;
        plen_r  <= q_rd_r.len;
        phold_r <= q_rd_r.hold;
      end
      OP_FIT_INIT: begin
        idx_r   <= '0;
        pos_r   <= '0;
        found_r <= 1'b0;
      end
      OP_FIT_STEP: begin
        if (fit_hit) begin
          found_r <= 1'b1;
          slot_r  <= idx_r;
        end else begin
          pos_r <= blk_end;
          idx_r <= idx_p1;
        end
      end
      OP_FIT_END: begin
        found_r <= end_ok;
        slot_r  <= blk_cnt_r;
      end
      OP_SHIFT_INIT: idx_r <= blk_cnt_r;
      OP_SHIFT_WR:   idx_r <= idx_m1;
      OP_INSERT: begin
        if (!retry_r) begin
          res_placed_r <= 1'b1;
          res_addr_r   <= pos_r[23:0];
        end
      end
      OP_OVF: res_ovf_r <= 1'b1;
      OP_OUT: begin
        out_placed_r <= res_placed_r;
        out_addr_r   <= res_addr_r;
        out_ovf_r    <= res_ovf_r;
        out_wait_r   <= wait_r;
        out_rel_r    <= last_rel_r;
      end
      default: ;
    endcase
  end

  // Status to the sequencer
  always_comb begin
    sts.cnt_zero     = (blk_cnt_r == '0);
    sts.idx_last     = (idx_p1 == blk_cnt_r);
    sts.min_gt_limit = (min_r > limit);
    sts.is_finish    = type_r;
    sts.fit_hit      = fit_hit;
    sts.found        = found_r;
    sts.tbl_full     = (blk_cnt_r >= BLK_CW'(MAX_BLOCKS));
    sts.q_empty      = (q_cnt_r == '0);
    sts.q_full       = (q_cnt_r >= Q_CW'(QUEUE_DEPTH));
    sts.idx_eq_slot  = (idx_r == slot_r);
    sts.retry        = retry_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid             = out_valid_r;
  assign out_placed_now        = out_placed_r;
  assign out_start_address     = out_addr_r;
  assign out_waited_total      = out_wait_r;
  assign out_last_release_time = out_rel_r;
  assign out_overflow          = out_ovf_r;

endmodule

`default_nettype wire

[rtl/first_fit_allocator_timed_release.sv]
// ------------------------------------------------------------------------
// first_fit_allocator_timed_release
// First-fit allocator of a linear memory with timed release and a FIFO
// of waiting requests.
//
//   channel | direction | handshake              | word
//   in_     | input     | in_valid / in_ready    | req_type, times, length
//   out_    | output    | out_valid / out_ready  | placement, counters
//   cfg_    | input     | cfg_we                 | memory_size
//
// A table scan makes one registered read per entry of the N blocks held.
// A plain request with nothing due scans the table once for a fit; when
// it lands below existing blocks, the insert shift first moves every
// entry above its slot up by one, one entry at a time.
// Each released group adds a minimum scan and a compaction pass, plus a
// fit scan and insert shift per retried request.
// Reset is synchronous, active low, and needs no clearing pass.
// A new word is taken once the previous result sits in the output
// register; a stalled output holds the sequencer only at its last step.
// ------------------------------------------------------------------------
`default_nettype none

module first_fit_allocator_timed_release (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [23:0] cfg_wdata,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_req_type,
  input  wire  [30:0] in_arrival_time,
  input  wire  [23:0] in_block_length,
  input  wire  [30:0] in_hold_time,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_placed_now,
  output logic [23:0] out_start_address,
  output logic [31:0] out_waited_total,
  output logic [31:0] out_last_release_time,
  output logic        out_overflow
);
  import ffa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  ffa_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_req_type           (in_req_type),
    .in_arrival_time       (in_arrival_time),
    .in_block_length       (in_block_length),
    .in_hold_time          (in_hold_time),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_placed_now        (out_placed_now),
    .out_start_address     (out_start_address),
    .out_waited_total      (out_waited_total),
    .out_last_release_time (out_last_release_time),
    .out_overflow          (out_overflow),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule

`default_nettype wire

[rtl/ffa_checker.sv]
// ------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator, bound to the top level.
// ------------------------------------------------------------------------
`default_nettype none

`include "first_fit_allocator_timed_release_defines.svh"

module ffa_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_placed_now,
  input wire [23:0] out_start_address,
  input wire [31:0] out_waited_total,
  input wire        out_overflow
);

  // Hold a stalled result word
  `FFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_waited_total) && $stable(out_start_address), "result word changed while stalled")

  // A placed word never reports a drop
  `FFA_ASSERT_NOW(a_place_no_ovf, out_valid && out_placed_now, !out_overflow, "placed and overflow together")

  // Unplaced words carry a zero address
  `FFA_ASSERT_NOW(a_addr_zero, out_valid && !out_placed_now, out_start_address == 24'd0, "address set without placement")

  // Busy after taking a word
  `FFA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "input taken again without processing")

endmodule

bind first_fit_allocator_timed_release ffa_checker u_ffa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_placed_now    (out_placed_now),
  .out_start_address (out_start_address),
  .out_waited_total  (out_waited_total),
  .out_overflow      (out_overflow)
);

`default_nettype wire
